[sv/itda_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itda_pkg
// Types and constants shared by the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int WORD_W        = 32;
  localparam int CHAR_W        = 6;
  localparam int NUM_DIGITS    = 10;
  localparam int DIGIT_W       = 4;
  localparam int DEC_RADIX     = 10;
  localparam int BITS_PER_STEP = 2;
  localparam int CONV_STEPS    = WORD_W / BITS_PER_STEP;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  localparam logic MODE_SIGNED   = 1'b0;
  localparam logic MODE_UNSIGNED = 1'b1;

  typedef logic [$clog2(NUM_DIGITS)-1:0] digit_idx_t;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last;
  } out_item_t;

  // Classified work item: sign flag and unsigned magnitude.
  typedef struct packed {
    logic              neg;
    logic [WORD_W-1:0] mag;
  } job_t;

endpackage
`default_nettype wire

[sv/int_to_decimal_ascii_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Each word gives 1 to 11 characters, converted one word at a time by the
// shift-and-add-3 unit, which handles two bits per cycle; the job queue
// can take new words while the back end is busy with the current one.
// Reset (rst, synchronous) empties the job queue and idles the back end.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire itda_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output itda_pkg::out_item_t     out_data
);

  itda_pkg::job_t front_job;
  itda_pkg::job_t q_data;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  itda_front u_front (
    .item (in_data),
    .job  (front_job)
  );

  itda_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (in_valid && in_ready),
    .wr_data (front_job),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  assign in_ready = !q_full;

  itda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("job queue reports full and empty together");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.text_char == itda_pkg::ASCII_MINUS)) |-> !out_data.last)
    else $error("minus sign marked as last character");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.text_char == itda_pkg::ASCII_MINUS) ||
                   ((out_data.text_char >= itda_pkg::ASCII_ZERO) &&
                    (out_data.text_char <= itda_pkg::ASCII_ZERO + itda_pkg::CHAR_W'(9)))))
    else $error("output character is neither a digit nor a minus sign");

endmodule
`default_nettype wire

[sv/itda_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itda_front
// Classifies an input word: decides the sign and forms the magnitude.
// ----------------------------------------------------------------------------
module itda_front (
  input  wire itda_pkg::in_item_t item,
  output itda_pkg::job_t          job
);

  logic neg;

  // In signed mode a set top bit means negative; the two's complement
  // negation also gives the right magnitude for the most negative value.
  assign neg = (item.action == itda_pkg::MODE_SIGNED) && item.value[itda_pkg::WORD_W-1];

  always_comb begin
    job.neg = neg;
    job.mag = neg ? (~item.value + itda_pkg::WORD_W'(1)) : item.value;
  end

endmodule
`default_nettype wire

[sv/itda_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itda_fifo
// Short queue of classified jobs between the front and the back end.
// ----------------------------------------------------------------------------
module itda_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire itda_pkg::job_t wr_data,
  output logic                full,
  input  wire logic           pop,
  output itda_pkg::job_t      rd_data,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  itda_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        mem[wr_ptr] <= wr_data;
        wr_ptr      <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/itda_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itda_back
// Converts a magnitude to BCD by shift-and-add-3, two bits per cycle, then
// sends the sign and the digits out one character per transaction.
// ----------------------------------------------------------------------------
module itda_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire itda_pkg::job_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output itda_pkg::out_item_t  out_data
);

  localparam int SCW = $clog2(itda_pkg::CONV_STEPS);
  localparam int ADJ = ((2 ** itda_pkg::DIGIT_W) - itda_pkg::DEC_RADIX) / 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_t;

  typedef logic [itda_pkg::NUM_DIGITS-1:0][itda_pkg::DIGIT_W-1:0] bcd_t;

  back_state_t                  state;
  logic [itda_pkg::WORD_W-1:0]  bin;
  bcd_t                         bcd;
  logic [SCW-1:0]               step_cnt;
  logic                         neg_pend;
  itda_pkg::digit_idx_t         pos;

  logic [itda_pkg::WORD_W-1:0]  bin_step;
  bcd_t                         bcd_step;
  itda_pkg::digit_idx_t         lead;
  logic [itda_pkg::CHAR_W-1:0]  digit_char;
  logic                         emit_load;

  always_comb begin
    bcd_step = bcd;
    bin_step = bin;
    for (int b = 0; b < itda_pkg::BITS_PER_STEP; b++) begin
      for (int d = 0; d < itda_pkg::NUM_DIGITS; d++) begin
        if (bcd_step[d] >= itda_pkg::DIGIT_W'(itda_pkg::DEC_RADIX / 2)) begin
          bcd_step[d] = bcd_step[d] + itda_pkg::DIGIT_W'(ADJ);
        end
      end
      {bcd_step, bin_step} = {bcd_step, bin_step} << 1;
    end
  end

  // Highest nonzero digit; zero itself leaves the units digit.
  always_comb begin
    lead = '0;
    for (int d = 0; d < itda_pkg::NUM_DIGITS; d++) begin
      if (bcd[d] != '0) begin
        lead = itda_pkg::digit_idx_t'(d);
      end
    end
  end

  assign digit_char = itda_pkg::ASCII_ZERO + itda_pkg::CHAR_W'(bcd[pos]);
  assign emit_load  = (state == ST_EMIT) && (!out_valid || out_ready);
  assign q_pop      = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new character loaded on this edge keeps the output valid.
      if (out_valid && out_ready && !emit_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            bin      <= q_data.mag;
            bcd      <= '0;
            neg_pend <= q_data.neg;
            step_cnt <= '0;
            state    <= ST_CONV;
          end
        end
        ST_CONV: begin
          bin      <= bin_step;
          bcd      <= bcd_step;
          step_cnt <= step_cnt + SCW'(1);
          if (step_cnt == SCW'(itda_pkg::CONV_STEPS - 1)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pos   <= lead;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_valid <= 1'b1;
            if (neg_pend) begin
              out_data.text_char <= itda_pkg::ASCII_MINUS;
              out_data.last      <= 1'b0;
              neg_pend           <= 1'b0;
            end else begin
              out_data.text_char <= digit_char;
              out_data.last      <= (pos == '0);
              if (pos == '0) begin
                state <= ST_IDLE;
              end else begin
                pos <= pos - itda_pkg::digit_idx_t'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to decimal ASCII converter. Words in
// signed and unsigned mode go through a valid/ready driver. Every accepted
// word is expanded into its expected characters. A monitor compares each
// character the block emits against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS   = 310;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_AFTER     = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int CALM_START     = 2000;
  localparam int CALM_END       = 4000;
  localparam int IDLE_PCT       = 33;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  itda_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  itda_pkg::out_item_t out_data;

  itda_pkg::in_item_t  pending_words[$];
  itda_pkg::out_item_t expected_chars[$];
  int                  cycle_cnt   = 0;
  int                  words_sent  = 0;
  int                  error_cnt   = 0;
  int                  hold_cnt    = 0;
  logic                hold_done   = 1'b0;
  logic                calm;

  int_to_decimal_ascii_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Neither side idles inside this window.
  assign calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);

  // Appends the characters of one word to the expected stream.
  function automatic void predict_text(itda_pkg::in_item_t word);
    logic                        neg;
    logic [itda_pkg::WORD_W-1:0]  mag;
    logic [itda_pkg::DIGIT_W-1:0] digits[itda_pkg::NUM_DIGITS];
    int                          nd;
    itda_pkg::out_item_t         ch;
    neg = (word.action == itda_pkg::MODE_SIGNED) && word.value[itda_pkg::WORD_W-1];
    mag = neg ? (~word.value + 1'b1) : word.value;
    nd  = 0;
    do begin
      digits[nd] = itda_pkg::DIGIT_W'(mag % 32'd10);
      mag        = mag / 32'd10;
      nd++;
    end while (mag != '0 && nd < itda_pkg::NUM_DIGITS);
    if (neg) begin
      ch.text_char = itda_pkg::ASCII_MINUS;
      ch.last      = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      ch.text_char = itda_pkg::ASCII_ZERO + itda_pkg::CHAR_W'(digits[i]);
      ch.last      = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void queue_word(logic mode, logic [itda_pkg::WORD_W-1:0] value);
    itda_pkg::in_item_t word;
    word.action = mode;
    word.value  = value;
    pending_words.push_back(word);
  endfunction

  // Driver: a new word is offered only when the line is free or the current
  // transaction completes on this edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(in_data);
        words_sent <= words_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off so the input side backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && words_sent >= HOLD_AFTER) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    itda_pkg::out_item_t exp_ch;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: text_char=%0d last=%0b",
               out_data.text_char, out_data.last);
        error_cnt++;
      end else begin
        exp_ch = expected_chars.pop_front();
        if (out_data.text_char !== exp_ch.text_char) begin
          $error("text_char: expected %0d, actual %0d",
                 exp_ch.text_char, out_data.text_char);
          error_cnt++;
        end
        if (out_data.last !== exp_ch.last) begin
          $error("last: expected %0b, actual %0b", exp_ch.last, out_data.last);
          error_cnt++;
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [itda_pkg::WORD_W-1:0] value;
    logic [itda_pkg::WORD_W-1:0] pow10;
    logic                        mode;

    // Directed words: zero, the most negative value, both ends of each
    // mode and the digit-count boundaries.
    queue_word(itda_pkg::MODE_SIGNED,   32'd0);
    queue_word(itda_pkg::MODE_UNSIGNED, 32'd0);
    queue_word(itda_pkg::MODE_SIGNED,   32'h8000_0000);
    queue_word(itda_pkg::MODE_UNSIGNED, 32'h8000_0000);
    queue_word(itda_pkg::MODE_SIGNED,   32'hFFFF_FFFF);
    queue_word(itda_pkg::MODE_UNSIGNED, 32'hFFFF_FFFF);
    queue_word(itda_pkg::MODE_SIGNED,   32'h7FFF_FFFF);
    queue_word(itda_pkg::MODE_UNSIGNED, 32'h7FFF_FFFF);
    queue_word(itda_pkg::MODE_SIGNED,   32'd1);
    queue_word(itda_pkg::MODE_SIGNED,   32'd9);
    queue_word(itda_pkg::MODE_UNSIGNED, 32'd10);
    queue_word(itda_pkg::MODE_SIGNED,   32'd99);
    queue_word(itda_pkg::MODE_UNSIGNED, 32'd100);
    queue_word(itda_pkg::MODE_SIGNED,   32'd999_999_999);
    queue_word(itda_pkg::MODE_UNSIGNED, 32'd1_000_000_000);
    queue_word(itda_pkg::MODE_SIGNED,   -32'sd10);
    queue_word(itda_pkg::MODE_SIGNED,   -32'sd1_000_000_000);
    queue_word(itda_pkg::MODE_UNSIGNED, 32'd4_000_000_000);
    queue_word(itda_pkg::MODE_SIGNED,   32'h8000_0001);
    queue_word(itda_pkg::MODE_UNSIGNED, 32'h5555_5555);
    queue_word(itda_pkg::MODE_SIGNED,   32'hAAAA_AAAA);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      mode = 1'($urandom_range(1));
      case ($urandom_range(3))
        0: value = $urandom_range(999);
        1: begin
          // Near a power of ten, where the digit count changes.
          pow10 = 32'd1;
          repeat ($urandom_range(9)) pow10 = pow10 * 32'd10;
          value = pow10 + $urandom_range(2) - 32'd1;
          if ($urandom_range(1)) value = ~value + 1'b1;
        end
        2: value = ~($urandom_range(999)) + 1'b1;
        default: value = $urandom;
      endcase
      queue_word(mode, value);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sampled mid-cycle so the driver's updates from the last edge are seen.
    do @(negedge clk);
    while (pending_words.size() > 0 || in_valid || expected_chars.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_cnt == 0 && expected_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
sv/itda_pkg.sv
sv/itda_front.sv
sv/itda_fifo.sv
sv/itda_back.sv
sv/int_to_decimal_ascii_top.sv
tb/tb_top.sv
